// ===== sv/hrhp_pkg.sv =====
// shared types and constants of the http response header parser
// no dependencies; used by hrhp_line_state and the top level
`default_nettype none

package hrhp_pkg;

  // characters of interest
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  localparam int unsigned LINE_LEN_BITS = 5;
  localparam logic [LINE_LEN_BITS-1:0] NAME_LEN = 5'd14;
  localparam logic [LINE_LEN_BITS-1:0] LINE_LEN_MAX = '1;

  // last four characters " 200" before a closing space
  localparam logic [31:0] STATUS_TAIL = 32'h2032_3030;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_HEADERS_END = 3'd1,
    EV_BODY_LAST   = 3'd2,
    EV_BAD_STATUS  = 3'd3,
    EV_BAD_LENGTH  = 3'd4,
    EV_NO_LENGTH   = 3'd5,
    EV_IGNORED     = 3'd6
  } event_t;

  typedef enum logic [4:0] {
    PH_STATUS  = 5'b00001,
    PH_HEADERS = 5'b00010,
    PH_BODY    = 5'b00100,
    PH_DONE    = 5'b01000,
    PH_FAILED  = 5'b10000
  } phase_t;

  typedef enum logic [5:0] {
    VS_BEFORE_COLON = 6'b000001,
    VS_SKIP         = 6'b000010,
    VS_POS          = 6'b000100,
    VS_NEG          = 6'b001000,
    VS_STOP         = 6'b010000,
    VS_NEG_STOP     = 6'b100000
  } scan_t;

  // per-byte commands from the top level to the line tracker
  typedef struct packed {
    logic       take;
    logic       restart;
    logic       end_line;
    logic       feed_cr;
    logic       feed_char;
    logic [7:0] ch;
  } line_ctrl_t;

  // line summary used when a line ends
  typedef struct packed {
    logic empty;
    logic name_hit;
    logic status_ok;
    logic value_ok;
  } line_stat_t;

  function automatic logic [7:0] lower_of(logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  // lower-case "content-length"
  function automatic logic [7:0] name_char(logic [3:0] idx);
    case (idx)
      4'd0:    return 8'h63;
      4'd1:    return 8'h6F;
      4'd2:    return 8'h6E;
      4'd3:    return 8'h74;
      4'd4:    return 8'h65;
      4'd5:    return 8'h6E;
      4'd6:    return 8'h74;
      4'd7:    return 8'h2D;
      4'd8:    return 8'h6C;
      4'd9:    return 8'h65;
      4'd10:   return 8'h6E;
      4'd11:   return 8'h67;
      4'd12:   return 8'h74;
      4'd13:   return 8'h68;
      default: return 8'h00;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== sv/hrhp_byte_if.sv =====
// input byte channel of the http response header parser
// no dependencies
`default_nettype none

interface hrhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_response;

  modport source (output valid, output data_byte, output new_response, input ready);
  modport sink (input valid, input data_byte, input new_response, output ready);
endinterface

`default_nettype wire

// ===== sv/hrhp_result_if.sv =====
// result channel of the http response header parser
// no dependencies; LENGTH_BITS must match the parser's
`default_nettype none

interface hrhp_result_if #(
  parameter int unsigned LENGTH_BITS = 31
);
  logic                   valid;
  logic                   ready;
  logic                   body_valid;
  logic [7:0]             body_byte;
  logic [2:0]             event_res;
  logic [LENGTH_BITS-1:0] declared_length;
  logic [LENGTH_BITS-1:0] bytes_received;

  modport source (
    output valid, output body_valid, output body_byte, output event_res,
    output declared_length, output bytes_received, input ready
  );
  modport sink (
    input valid, input body_valid, input body_byte, input event_res,
    input declared_length, input bytes_received, output ready
  );
endinterface

`default_nettype wire

// ===== sv/hrhp_line_state.sv =====
// per-line tracking: name match, status tail, content-length value scan
// depends on hrhp_pkg
`default_nettype none

module hrhp_line_state #(
  parameter int unsigned LENGTH_BITS = 31
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire hrhp_pkg::line_ctrl_t    ctrl,
  output hrhp_pkg::line_stat_t         stat,
  output logic [LENGTH_BITS-1:0]       value
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  typedef struct packed {
    logic [hrhp_pkg::LINE_LEN_BITS-1:0] len;
    logic                               name_ok;
    logic [31:0]                        recent;
    logic                               status_ok;
    hrhp_pkg::scan_t                    scan;
    logic [LENGTH_BITS-1:0]             acc;
  } line_t;

  localparam line_t LINE_CLEAR = '{
    len: '0, name_ok: 1'b1, recent: '0, status_ok: 1'b0,
    scan: hrhp_pkg::VS_BEFORE_COLON, acc: '0
  };

  function automatic logic [LENGTH_BITS-1:0] accumulate(logic [LENGTH_BITS-1:0] acc,
                                                         logic [3:0] d);
    logic [LENGTH_BITS+3:0] wide;
    wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{LENGTH_BITS{1'b0}}, d};
    if (wide[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
      return LEN_MAX;
    end
    return wide[LENGTH_BITS-1:0];
  endfunction

  function automatic line_t feed(line_t s, logic [7:0] c);
    line_t r;
    logic  space;
    logic  digit;
    r = s;
    space = (c == hrhp_pkg::CH_SPACE) || (c == hrhp_pkg::CH_TAB) || (c == hrhp_pkg::CH_VT) ||
            (c == hrhp_pkg::CH_FF) || (c == hrhp_pkg::CH_CR);
    digit = (c >= hrhp_pkg::CH_ZERO) && (c <= hrhp_pkg::CH_NINE);
    if (s.len < hrhp_pkg::NAME_LEN &&
        hrhp_pkg::lower_of(c) != hrhp_pkg::name_char(s.len[3:0])) begin
      r.name_ok = 1'b0;
    end
    if (c == hrhp_pkg::CH_SPACE && s.recent == hrhp_pkg::STATUS_TAIL) begin
      r.status_ok = 1'b1;
    end
    r.recent = {s.recent[23:0], c};
    case (s.scan)
      hrhp_pkg::VS_BEFORE_COLON: begin
        if (c == hrhp_pkg::CH_COLON) begin
          r.scan = hrhp_pkg::VS_SKIP;
        end
      end
      hrhp_pkg::VS_SKIP: begin
        if (!space) begin
          if (c == hrhp_pkg::CH_PLUS) begin
            r.scan = hrhp_pkg::VS_POS;
          end else if (c == hrhp_pkg::CH_MINUS) begin
            r.scan = hrhp_pkg::VS_NEG;
          end else if (digit) begin
            r.scan = hrhp_pkg::VS_POS;
            r.acc = accumulate(s.acc, c[3:0]);
          end else begin
            r.scan = hrhp_pkg::VS_STOP;
          end
        end
      end
      hrhp_pkg::VS_POS: begin
        if (digit) begin
          r.acc = accumulate(s.acc, c[3:0]);
        end else begin
          r.scan = hrhp_pkg::VS_STOP;
        end
      end
      hrhp_pkg::VS_NEG: begin
        if (digit) begin
          r.acc = accumulate(s.acc, c[3:0]);
        end else begin
          r.scan = hrhp_pkg::VS_NEG_STOP;
        end
      end
      default: begin
      end
    endcase
    if (s.len != hrhp_pkg::LINE_LEN_MAX) begin
      r.len = s.len + 1'b1;
    end
    return r;
  endfunction

  line_t line;
  line_t line_base;
  line_t line_cr;
  line_t line_next;

  always_comb begin
    line_base = ctrl.restart ? LINE_CLEAR : line;
    // a held carriage return that turned out to be data goes in first
    line_cr   = ctrl.feed_cr ? feed(line_base, hrhp_pkg::CH_CR) : line_base;
    line_next = ctrl.feed_char ? feed(line_cr, ctrl.ch) : line_cr;
    if (ctrl.end_line) begin
      line_next = LINE_CLEAR;
    end
  end

  always_comb begin
    stat.empty     = (line_base.len == '0);
    stat.name_hit  = line_base.name_ok && (line_base.len >= hrhp_pkg::NAME_LEN);
    stat.status_ok = line_base.status_ok;
    stat.value_ok  = (line_base.scan != hrhp_pkg::VS_BEFORE_COLON) &&
                     (line_base.scan != hrhp_pkg::VS_NEG) &&
                     (line_base.scan != hrhp_pkg::VS_NEG_STOP) &&
                     (line_base.acc != '0);
    value          = line_base.acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line <= LINE_CLEAR;
    end else if (ctrl.take) begin
      line <= line_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/http_response_header_parser_top.sv =====
// top level of the http response header parser
// depends on hrhp_pkg, hrhp_byte_if, hrhp_result_if and hrhp_line_state
//
// Takes an HTTP response one byte per transfer on byte_stream and returns
// exactly one result per byte on result_stream. A byte can be taken in every
// ready cycle: the whole per-byte decision is made from the state registers
// and the incoming byte, and the result is registered. A two-entry output
// stage (output register plus skid register) keeps byte_stream ready while
// one result waits for result_stream; ready only drops once both entries
// are full. Line endings are LF with an optional CR just before it; a CR is
// held back one byte until it is known not to be part of a line ending. The
// first non-empty line must carry " 200 ", a header whose name starts with
// Content-Length (any case) sets the declared length (saturating at
// 2^LENGTH_BITS-1, last one wins) if its value is positive, an empty line
// opens the body if a length is set, and body bytes are passed out and
// counted until the declared length is reached. Setting new_response
// restarts the parse with that byte. No clearing pass follows reset.
`default_nettype none

module http_response_header_parser_top #(
  parameter int unsigned LENGTH_BITS = 31
) (
  input wire logic            clk,
  input wire logic            rst,
  hrhp_byte_if.sink           byte_stream,
  hrhp_result_if.source       result_stream
);

  typedef struct packed {
    logic                   body_valid;
    logic [7:0]             body_byte;
    hrhp_pkg::event_t       event_res;
    logic [LENGTH_BITS-1:0] declared_length;
    logic [LENGTH_BITS-1:0] bytes_received;
  } result_t;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // parse state
  hrhp_pkg::phase_t       phase;
  hrhp_pkg::phase_t       phase_next;
  logic                   held_cr;
  logic                   held_cr_next;
  logic [LENGTH_BITS-1:0] length_value;
  logic [LENGTH_BITS-1:0] length_value_next;
  logic [LENGTH_BITS-1:0] body_count;
  logic [LENGTH_BITS-1:0] body_count_next;

  // values after an optional restart, before this byte
  hrhp_pkg::phase_t       phase_base;
  logic                   held_cr_base;
  logic [LENGTH_BITS-1:0] length_base;
  logic [LENGTH_BITS-1:0] count_base;

  // output stage
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  result_t res;

  logic take;
  logic out_fire;
  logic [7:0] ch;

  hrhp_pkg::line_ctrl_t   line_ctrl;
  hrhp_pkg::line_stat_t   line_stat;
  logic [LENGTH_BITS-1:0] line_value;

  assign byte_stream.ready = !skid_valid;
  assign take     = byte_stream.valid && byte_stream.ready;
  assign out_fire = out_valid && result_stream.ready;
  assign ch       = byte_stream.data_byte;

  hrhp_line_state #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_line_state (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (line_ctrl),
    .stat  (line_stat),
    .value (line_value)
  );

  // a new response starts from the reset values with this very byte
  always_comb begin
    if (byte_stream.new_response) begin
      phase_base   = hrhp_pkg::PH_STATUS;
      held_cr_base = 1'b0;
      length_base  = '0;
      count_base   = '0;
    end else begin
      phase_base   = phase;
      held_cr_base = held_cr;
      length_base  = length_value;
      count_base   = body_count;
    end
  end

  always_comb begin
    phase_next        = phase_base;
    held_cr_next      = held_cr_base;
    length_value_next = length_base;
    body_count_next   = count_base;

    line_ctrl.take      = take;
    line_ctrl.restart   = byte_stream.new_response;
    line_ctrl.end_line  = 1'b0;
    line_ctrl.feed_cr   = 1'b0;
    line_ctrl.feed_char = 1'b0;
    line_ctrl.ch        = ch;

    res.body_valid = 1'b0;
    res.body_byte  = '0;
    res.event_res  = hrhp_pkg::EV_NONE;

    case (phase_base)
      hrhp_pkg::PH_STATUS, hrhp_pkg::PH_HEADERS: begin
        if (ch == hrhp_pkg::CH_LF) begin
          held_cr_next       = 1'b0;
          line_ctrl.end_line = 1'b1;
          if (phase_base == hrhp_pkg::PH_STATUS) begin
            // blank lines ahead of the status line are skipped
            if (!line_stat.empty) begin
              if (line_stat.status_ok) begin
                phase_next = hrhp_pkg::PH_HEADERS;
              end else begin
                phase_next    = hrhp_pkg::PH_FAILED;
                res.event_res = hrhp_pkg::EV_BAD_STATUS;
              end
            end
          end else if (line_stat.empty) begin
            // end of headers
            if (length_base == '0) begin
              phase_next    = hrhp_pkg::PH_FAILED;
              res.event_res = hrhp_pkg::EV_NO_LENGTH;
            end else begin
              phase_next    = hrhp_pkg::PH_BODY;
              res.event_res = hrhp_pkg::EV_HEADERS_END;
            end
          end else if (line_stat.name_hit) begin
            if (line_stat.value_ok) begin
              length_value_next = line_value;
            end else begin
              phase_next    = hrhp_pkg::PH_FAILED;
              res.event_res = hrhp_pkg::EV_BAD_LENGTH;
            end
          end
        end else begin
          // held cr was not a line ending: it is line data after all
          line_ctrl.feed_cr   = held_cr_base;
          line_ctrl.feed_char = (ch != hrhp_pkg::CH_CR);
          held_cr_next        = (ch == hrhp_pkg::CH_CR);
        end
      end
      hrhp_pkg::PH_BODY: begin
        if (count_base != LEN_MAX) begin
          body_count_next = count_base + 1'b1;
        end
        res.body_valid = 1'b1;
        res.body_byte  = ch;
        if (body_count_next >= length_base) begin
          phase_next    = hrhp_pkg::PH_DONE;
          res.event_res = hrhp_pkg::EV_BODY_LAST;
        end
      end
      default: begin
        // done or failed: bytes are ignored until the next response
        res.event_res = hrhp_pkg::EV_IGNORED;
      end
    endcase

    res.declared_length = length_value_next;
    res.bytes_received  = body_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= hrhp_pkg::PH_STATUS;
      held_cr      <= 1'b0;
      length_value <= '0;
      body_count   <= '0;
    end else if (take) begin
      phase        <= phase_next;
      held_cr      <= held_cr_next;
      length_value <= length_value_next;
      body_count   <= body_count_next;
    end
  end

  // output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (take) begin
      if (out_valid && !out_fire) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_data <= skid_data;
      end
    end else if (take) begin
      if (out_valid && !out_fire) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end
  end

  assign result_stream.valid           = out_valid;
  assign result_stream.body_valid      = out_data.body_valid;
  assign result_stream.body_byte       = out_data.body_byte;
  assign result_stream.event_res       = out_data.event_res;
  assign result_stream.declared_length = out_data.declared_length;
  assign result_stream.bytes_received  = out_data.bytes_received;

endmodule

`default_nettype wire
